### src/sofl_pkg.sv
package sofl_pkg;

  localparam int TAPS    = 8;
  localparam int TAP_W   = $clog2(TAPS);
  localparam int PH_W    = 24;
  localparam int INC_W   = 23;
  localparam int AMP_W   = 15;
  localparam int COEF_W  = 15;
  localparam int SAMP_W  = 16;
  localparam int ACC_W   = 42;
  localparam int SPLIT_W = 21;
  localparam int PROD_W  = ACC_W + AMP_W + 1;
  localparam int FRAC_W  = 38;
  localparam int CFG_W   = 23;

  localparam logic CFG_PHASE_INC = 1'b0;
  localparam logic CFG_AMPLITUDE = 1'b1;

  localparam logic [INC_W-1:0] INC_RST = 23'd62915;
  localparam logic [AMP_W-1:0] AMP_RST = 15'd500;

  typedef struct packed {
    logic             load_out;
    logic             phase_upd;
    logic             mac;
    logic [TAP_W-1:0] tap;
    logic             scale_lo;
    logic             scale_hi;
    logic             finish;
  } sofl_cmd_t;

  typedef struct packed {
    logic busy;
    logic parity;
  } sofl_stat_t;

  function automatic logic [COEF_W-1:0] coeff_q16(input logic [TAP_W-1:0] idx);
    logic [COEF_W-1:0] c;
    unique case (idx)
      3'd0:    c = 15'd655;
      3'd1:    c = 15'd3277;
      3'd2:    c = 15'd7864;
      3'd3:    c = 15'd20972;
      3'd4:    c = 15'd20972;
      3'd5:    c = 15'd7864;
      3'd6:    c = 15'd3277;
      default: c = 15'd655;
    endcase
    return c;
  endfunction

endpackage

### src/sofl_ctrl.sv
module sofl_ctrl import sofl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_advance,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_slot_channel,
  output sofl_cmd_t  cmd,
  output sofl_stat_t stat
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PHASE  = 3'd1;
  localparam logic [2:0] ST_MAC    = 3'd2;
  localparam logic [2:0] ST_SCL_LO = 3'd3;
  localparam logic [2:0] ST_SCL_HI = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [TAP_W-1:0] tap_r, tap_nxt;
  logic             parity_r, parity_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             chan_r, chan_nxt;
  logic             accept, fire;

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign fire     = accept && in_advance;

  always_comb begin
    state_nxt     = state_r;
    tap_nxt       = tap_r;
    parity_nxt    = parity_r;
    out_valid_nxt = out_valid_r;
    chan_nxt      = chan_r;
    cmd           = '0;
    cmd.tap       = tap_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (fire) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          chan_nxt      = parity_r;
          parity_nxt    = ~parity_r;
          if (parity_r) begin
            state_nxt = ST_PHASE;
          end
        end
      end
      ST_PHASE: begin
        cmd.phase_upd = 1'b1;
        tap_nxt       = '0;
        state_nxt     = ST_MAC;
      end
      ST_MAC: begin
        cmd.mac = 1'b1;
        tap_nxt = tap_r + 1'b1;
        if (tap_r == TAP_W'(TAPS - 1)) begin
          state_nxt = ST_SCL_LO;
        end
      end
      ST_SCL_LO: begin
        cmd.scale_lo = 1'b1;
        state_nxt    = ST_SCL_HI;
      end
      ST_SCL_HI: begin
        cmd.scale_hi = 1'b1;
        state_nxt    = ST_FIN;
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tap_r       <= '0;
      parity_r    <= 1'b0;
      out_valid_r <= 1'b0;
      chan_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tap_r       <= tap_nxt;
      parity_r    <= parity_nxt;
      out_valid_r <= out_valid_nxt;
      chan_r      <= chan_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_slot_channel = chan_r;
  assign stat.busy        = (state_r != ST_IDLE);
  assign stat.parity      = parity_r;

endmodule

### src/sofl_dp.sv
module sofl_dp import sofl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  sofl_cmd_t                cmd,
  output logic signed [SAMP_W-1:0] out_sample_out
);

  logic [INC_W-1:0]         inc_r;
  logic [AMP_W-1:0]         amp_r;
  logic signed [PH_W-1:0]   saw_r;
  logic signed [PH_W-1:0]   hist_r [TAPS];
  logic [TAP_W-1:0]         wpos_r;
  logic signed [SAMP_W-1:0] held_r;
  logic signed [SAMP_W-1:0] samp_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [SPLIT_W+AMP_W-1:0] lo_r;
  logic signed [PROD_W-1:0] prod_r;

  logic signed [PH_W+1:0]       ph_sum, ph_fold;
  logic [TAP_W-1:0]             rd_idx;
  logic signed [PH_W+COEF_W:0]  mac_prod;
  logic signed [ACC_W-SPLIT_W+AMP_W:0] hi_prod;
  logic signed [PROD_W-1:0]     prod_nxt;
  logic signed [PROD_W-FRAC_W-1:0] quo;
  logic signed [SAMP_W-1:0]     sat;

  // phase step with fold by 2.0 past 1.0
  always_comb begin
    ph_sum = {{2{saw_r[PH_W-1]}}, saw_r} + $signed({3'b000, inc_r});
    if (ph_sum > 26'sd4194304) begin
      ph_fold = ph_sum - 26'sd8388608;
    end else begin
      ph_fold = ph_sum;
    end
  end

  // shared tap multiply
  assign rd_idx   = wpos_r + cmd.tap;
  assign mac_prod = hist_r[rd_idx] * $signed({1'b0, coeff_q16(cmd.tap)});

  // gain split in two partial products
  assign hi_prod  = $signed(acc_r[ACC_W-1:SPLIT_W]) * $signed({1'b0, amp_r});
  assign prod_nxt = $signed({hi_prod, {SPLIT_W{1'b0}}})
                  + $signed({{(PROD_W-SPLIT_W-AMP_W){1'b0}}, lo_r});

  // truncate toward zero, then saturate
  always_comb begin
    quo = prod_r[PROD_W-1:FRAC_W];
    if (prod_r[PROD_W-1] && (|prod_r[FRAC_W-1:0])) begin
      quo = quo + 1'b1;
    end
    if (quo > 20'sd32767) begin
      sat = 16'sh7fff;
    end else if (quo < -20'sd32768) begin
      sat = -16'sh8000;
    end else begin
      sat = quo[SAMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r  <= INC_RST;
      amp_r  <= AMP_RST;
      saw_r  <= '0;
      wpos_r <= '0;
      held_r <= '0;
      for (int i = 0; i < TAPS; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PHASE_INC: inc_r <= cfg_data[INC_W-1:0];
          CFG_AMPLITUDE: amp_r <= cfg_data[AMP_W-1:0];
          default: ;
        endcase
      end
      if (cmd.phase_upd) begin
        saw_r          <= ph_fold[PH_W-1:0];
        hist_r[wpos_r] <= ph_fold[PH_W-1:0];
      end
      if (cmd.finish) begin
        held_r <= sat;
        wpos_r <= wpos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      samp_r <= held_r;
    end
    if (cmd.phase_upd) begin
      acc_r <= '0;
    end else if (cmd.mac) begin
      acc_r <= acc_r + ACC_W'(mac_prod);
    end
    if (cmd.scale_lo) begin
      lo_r <= acc_r[SPLIT_W-1:0] * amp_r;
    end
    if (cmd.scale_hi) begin
      prod_r <= prod_nxt;
    end
  end

  assign out_sample_out = samp_r;

endmodule

### src/saw_oscillator_fir_lowpass_unit.sv
// sawtooth oscillator with an 8-tap lowpass, paced by audio transmit slots
//
// in channel (in_valid/in_ready/in_advance): one word per transmit slot;
//   advance = 1 sends the held sample, advance = 0 is a no-op word with no result
// out channel (out_valid/out_ready): held sample and slot parity, registered,
//   valid the cycle after the input word is taken
// cfg port: cfg_we/cfg_index/cfg_data, 0 = phase increment (Q2.22), 1 = amplitude;
//   write only while idle, takes effect at once
// throughput: an even slot takes 1 cycle; an odd slot takes 13 cycles
//   (the accepting cycle, phase update, 8 cycles through the single
//   multiply-accumulate unit, 2 cycles of split gain multiply, 1 cycle of
//   rounding and clamp), then the next word may be taken
// a new word is taken only once the output register is empty or being drained,
//   so a stalled receiver holds off the input side
// reset (rst_n low, synchronous): phase, history, slot parity and held sample
//   clear to zero, increment returns to 62915 and amplitude to 500
module saw_oscillator_fir_lowpass_unit import sofl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_advance,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [SAMP_W-1:0] out_sample_out,
  output logic                     out_slot_channel,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  sofl_cmd_t  cmd;
  sofl_stat_t stat;

  sofl_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_advance       (in_advance),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_slot_channel (out_slot_channel),
    .cmd              (cmd),
    .stat             (stat)
  );

  sofl_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .out_sample_out (out_sample_out)
  );

  a_adv_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_advance) |=> out_valid)
    else $error("advance word produced no output word");

  a_parity_flips: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_advance) |=> (stat.parity != $past(stat.parity)))
    else $error("slot parity did not toggle");

  a_noop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_advance && !out_valid) |=> !out_valid)
    else $error("no-op word produced an output word");

  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> !in_ready)
    else $error("input taken while sample update in progress");

endmodule

### tb/sofl_slot_checker.sv
`timescale 1ns / 100ps
module sofl_slot_checker import sofl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic                     in_advance,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [SAMP_W-1:0] out_sample_out,
  input  logic                     out_slot_channel,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  output int                       mismatch_count,
  output int                       slots_owed
);

  typedef struct packed {
    logic signed [SAMP_W-1:0] sample;
    logic                     channel;
  } slot_word_t;

  localparam longint LPF_COEF [TAPS] = '{655, 3277, 7864, 20972, 20972, 7864, 3277, 655};
  localparam longint PHASE_ONE = 64'sd4194304;
  localparam longint PHASE_TWO = 64'sd8388608;
  localparam longint SUM_SCALE = 64'sd1 <<< FRAC_W;

  logic [INC_W-1:0]         step_size;
  logic [AMP_W-1:0]         gain;
  logic                     slot_odd;
  logic signed [PH_W-1:0]   saw;
  logic signed [PH_W-1:0]   saw_hist [TAPS];
  logic [TAP_W-1:0]         hist_ptr;
  logic signed [SAMP_W-1:0] held;
  slot_word_t               owed_slots [$];

  // advance the sawtooth, push it into the history and filter to a new held sample
  function automatic void next_filtered_sample();
    longint           ph;
    longint           acc;
    longint           scaled;
    logic [TAP_W-1:0] idx;
    int               k;
    ph = longint'(saw) + longint'(step_size);
    if (ph > PHASE_ONE) begin
      ph = ph - PHASE_TWO;
    end
    saw = ph[PH_W-1:0];
    saw_hist[hist_ptr] = saw;
    acc = 0;
    for (k = 0; k < TAPS; k++) begin
      idx = hist_ptr + TAP_W'(k);
      acc = acc + LPF_COEF[k] * longint'(saw_hist[idx]);
    end
    hist_ptr = hist_ptr + 1'b1;
    scaled = (acc * longint'(gain)) / SUM_SCALE;
    if (scaled > 32767) begin
      scaled = 32767;
    end else if (scaled < -32768) begin
      scaled = -32768;
    end
    held = scaled[SAMP_W-1:0];
  endfunction

  task automatic note_mismatch(input string what, input longint want, input longint got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    slot_word_t want;
    if (!rst_n) begin
      step_size = 23'd62915;
      gain      = 15'd500;
      slot_odd  = 1'b0;
      saw       = '0;
      hist_ptr  = '0;
      held      = '0;
      for (int k = 0; k < TAPS; k++) begin
        saw_hist[k] = '0;
      end
      owed_slots.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (owed_slots.size() == 0) begin
          note_mismatch("unexpected word sample", 0, out_sample_out);
        end else begin
          want = owed_slots.pop_front();
          if (want.sample !== out_sample_out) begin
            note_mismatch("sample_out", want.sample, out_sample_out);
          end
          if (want.channel !== out_slot_channel) begin
            note_mismatch("slot_channel", want.channel, out_slot_channel);
          end
        end
      end
      if (in_valid && in_ready && in_advance) begin
        want.sample  = held;
        want.channel = slot_odd;
        owed_slots.push_back(want);
        if (slot_odd) begin
          next_filtered_sample();
        end
        slot_odd = ~slot_odd;
      end
      if (cfg_we) begin
        if (cfg_index == CFG_PHASE_INC) begin
          step_size = cfg_data[INC_W-1:0];
        end else begin
          gain = cfg_data[AMP_W-1:0];
        end
      end
    end
    slots_owed = owed_slots.size();
  end

endmodule

### tb/saw_oscillator_fir_lowpass_unit_tb.sv
`timescale 1ns / 100ps
module saw_oscillator_fir_lowpass_unit_tb;
  import sofl_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE_TICKS = 24;
  localparam int SLOT_TARGET  = 1000;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic                     in_advance;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [SAMP_W-1:0] out_sample_out;
  logic                     out_slot_channel;
  logic                     cfg_we;
  logic                     cfg_index;
  logic [CFG_W-1:0]         cfg_data;
  int                       mismatch_count;
  int                       slots_owed;
  int                       quiet_cycles;
  int                       slots_sent;

  saw_oscillator_fir_lowpass_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_advance       (in_advance),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_out   (out_sample_out),
    .out_slot_channel (out_slot_channel),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  sofl_slot_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_advance       (in_advance),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_out   (out_sample_out),
    .out_slot_channel (out_slot_channel),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .slots_owed       (slots_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver pacing: stretches of always ready, coin flips, short and long stalls
  initial begin
    int pace_mode;
    int pace_len;
    int tick;
    out_ready = 1'b0;
    forever begin
      pace_mode = $urandom_range(0, 3);
      pace_len  = $urandom_range(16, 160);
      for (tick = 0; tick < pace_len; tick++) begin
        @(negedge clk);
        case (pace_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 1) == 1);
          2:       out_ready <= ((tick % 7) > 2);
          default: out_ready <= ((tick % 24) < 4);
        endcase
      end
    end
  end

  task automatic send_slot(input logic adv);
    @(negedge clk);
    in_valid   <= 1'b1;
    in_advance <= adv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (adv) begin
      slots_sent++;
    end
  endtask

  task automatic pause_sender(input int gap);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (gap - 1) @(negedge clk);
  endtask

  task automatic drain_slots();
    @(negedge clk);
    in_valid <= 1'b0;
    while (slots_owed != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // odd slots keep computing after their word leaves, so let the filter finish
  task automatic retune(input logic [CFG_W-1:0] step_word, input logic [CFG_W-1:0] gain_word);
    drain_slots();
    repeat (SETTLE_TICKS) @(negedge clk);
    write_reg(CFG_PHASE_INC, step_word);
    write_reg(CFG_AMPLITUDE, gain_word);
  endtask

  task automatic run_slots(input int count);
    int goal;
    int burst;
    goal = slots_sent + count;
    while (slots_sent < goal) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && slots_sent < goal) begin
        send_slot($urandom_range(0, 99) >= 15);
        burst--;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: ;
        3:       drain_slots();
        default: pause_sender($urandom_range(1, 30));
      endcase
    end
  endtask

  initial begin
    int               phase_no;
    logic [CFG_W-1:0] step_word;
    logic [CFG_W-1:0] gain_word;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_advance = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_PHASE_INC;
    cfg_data   = '0;
    slots_sent = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings, no-op words between an even and an odd slot
    send_slot(1'b0);
    send_slot(1'b1);
    send_slot(1'b0);
    send_slot(1'b1);
    // land the phase exactly on +1.0, gain word with bits above the register
    retune(23'd4131389, 23'h7FFFFF);
    send_slot(1'b1);
    send_slot(1'b1);
    // hold +1.0 until the whole history saturates high
    retune('0, 23'h7FFFFF);
    repeat (16) send_slot(1'b1);

    phase_no = 0;
    while (slots_sent < SLOT_TARGET) begin
      case (phase_no)
        0: begin
          step_word = 23'd1;
          gain_word = 23'd32767;
        end
        1: begin
          step_word = 23'd4194304;
          gain_word = '0;
        end
        2: begin
          step_word = 23'h7FFFFF;
          gain_word = 23'd32767;
        end
        3: begin
          step_word = 23'd4194303;
          gain_word = 23'd1;
        end
        default: begin
          gain_word = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom)
                                                  : CFG_W'($urandom_range(0, 32767));
          case ($urandom_range(0, 3))
            0:       step_word = CFG_W'($urandom_range(1, 1 << 18));
            1:       step_word = CFG_W'($urandom_range(0, 4194304));
            default: step_word = CFG_W'($urandom);
          endcase
        end
      endcase
      retune(step_word, gain_word);
      run_slots($urandom_range(40, 90));
      phase_no++;
    end

    drain_slots();
    repeat (SETTLE_TICKS) @(negedge clk);
    if (mismatch_count == 0 && slots_owed == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
